// ===== rtl/nfps_pkg.sv =====
package nfps_pkg;

   localparam int COORD_W    = 8;
   localparam int DIM_W      = 9;
   localparam int PIX_ADDR_W = 2 * COORD_W;
   localparam int PIX_COUNT  = 1 << PIX_ADDR_W;
   localparam int PTR_W      = PIX_ADDR_W + 1;
   localparam int NB_W       = 3;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1 << COORD_W);
   localparam logic [NB_W-1:0]  NB_LAST = NB_W'(7);

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_POP,
      S_FETCH,
      S_TEST,
      S_NREAD,
      S_NCHK,
      S_DONE,
      S_CLEAN
   } state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_DEC,
      STEP_INC
   } step_type;

   typedef struct packed {
      step_type dx;
      step_type dy;
   } nb_step_type;

   typedef struct packed {
      logic clear;
      logic rewind;
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // neighbor order: up, down, left, right, up-left, down-left, up-right, down-right
   function automatic nb_step_type nb_step(input logic [NB_W-1:0] k);
      nb_step_type s;
      case (k)
         3'd0: s = '{dx: STEP_NONE, dy: STEP_DEC};
         3'd1: s = '{dx: STEP_NONE, dy: STEP_INC};
         3'd2: s = '{dx: STEP_DEC,  dy: STEP_NONE};
         3'd3: s = '{dx: STEP_INC,  dy: STEP_NONE};
         3'd4: s = '{dx: STEP_DEC,  dy: STEP_DEC};
         3'd5: s = '{dx: STEP_DEC,  dy: STEP_INC};
         3'd6: s = '{dx: STEP_INC,  dy: STEP_DEC};
         3'd7: s = '{dx: STEP_INC,  dy: STEP_INC};
         default: s = '{dx: STEP_NONE, dy: STEP_NONE};
      endcase
      return s;
   endfunction

   function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
      return (v > DIM_MAX) ? DIM_MAX : v;
   endfunction

endpackage

// ===== rtl/nfps_queue.sv =====
module nfps_queue
   import nfps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  q_ctl_type             ctl,
   input  logic [PIX_ADDR_W-1:0] push_data,
   output logic [PIX_ADDR_W-1:0] rd_data,
   output q_stat_type            stat
);

   logic [PIX_ADDR_W-1:0] mem [PIX_COUNT];
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [PIX_ADDR_W-1:0] rd_data_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctl.clear) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (ctl.rewind) begin
            head_in = '0;
         end else if (ctl.pop) begin
            head_in = head_ff + PTR_W'(1);
         end
         if (ctl.push) begin
            tail_in = tail_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         mem[tail_ff[PIX_ADDR_W-1:0]] <= push_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[head_ff[PIX_ADDR_W-1:0]];
      end
   end

   assign rd_data    = rd_data_ff;
   assign stat.empty = (head_ff == tail_ff);
   assign stat.full  = (tail_ff == PTR_W'(PIX_COUNT));

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> stat.empty)
      else $error("queue not empty after clear");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !stat.full)
      else $error("push into full queue");

endmodule

// ===== rtl/nearest_foreground_pixel_search.sv =====
// pixel write: accepted in any idle cycle, one per cycle, no result
// query: per dequeued pixel S_POP, S_FETCH, S_TEST; per neighbor S_NREAD, plus S_NCHK if in range,
//    set by the single read port of the pixel/visited memory; an out-of-range start goes to S_DONE
// after each result the visited flags are cleared by replaying the queue, each enqueued
//    pixel popped in turn in S_CLEAN, before the next transaction is taken
// reset: synchronous; an S_INIT pass over all 65536 addresses clears the visited flags with req_tready low
module nearest_foreground_pixel_search
   import nfps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // pos_x[7:0], pos_y[15:8], pixel_on[16], zero
   input  logic              req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // near_x[7:0], near_y[15:8]
   output logic              rsp_tuser,   // found
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [DIM_W-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [DIM_W-1:0]      w_ff, h_ff;
   logic [COORD_W-1:0]    cur_x_ff, cur_y_ff;
   logic [NB_W-1:0]       nb_k_ff;
   logic [PIX_ADDR_W-1:0] nb_addr_ff;
   logic [PIX_ADDR_W-1:0] init_ptr_ff;
   logic                  clean_pend_ff;
   logic                  found_ff;
   logic [COORD_W-1:0]    res_x_ff, res_y_ff;
   logic                  rsp_tvalid_ff;
   logic                  rsp_found_ff;
   logic [COORD_W-1:0]    rsp_x_ff, rsp_y_ff;

   logic [1:0]            pix_mem [PIX_COUNT];
   logic [1:0]            pix_rd_ff;

   logic                  img_we, vis_we, vis_wdata, pix_rd_en;
   logic [PIX_ADDR_W-1:0] pix_wa, pix_ra;

   q_ctl_type             q_ctl;
   q_stat_type            q_stat;
   logic [PIX_ADDR_W-1:0] q_push_data, q_rd_data;

   logic                  req_accept, rsp_accept;
   logic [COORD_W-1:0]    pos_x, pos_y;
   logic                  pixel_on;
   logic [DIM_W-1:0]      w_eff, h_eff;
   logic                  start_out;
   nb_step_type           step;
   logic                  nb_x_ok, nb_y_ok, nb_ok;
   logic [COORD_W-1:0]    nb_x, nb_y;

   assign pos_x    = req_tdata[COORD_W-1:0];
   assign pos_y    = req_tdata[2*COORD_W-1:COORD_W];
   assign pixel_on = req_tdata[2*COORD_W];

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid_ff && rsp_tready;

   assign w_eff     = dim_limit(width_ff);
   assign h_eff     = dim_limit(height_ff);
   assign start_out = ({1'b0, pos_x} >= w_eff) || ({1'b0, pos_y} >= h_eff);

   // neighbor position and bounds
   always_comb begin
      step    = nb_step(nb_k_ff);
      nb_x    = cur_x_ff;
      nb_y    = cur_y_ff;
      nb_x_ok = 1'b1;
      nb_y_ok = 1'b1;
      case (step.dx)
         STEP_DEC: begin
            nb_x    = cur_x_ff - COORD_W'(1);
            nb_x_ok = (cur_x_ff != '0);
         end
         STEP_INC: begin
            nb_x    = cur_x_ff + COORD_W'(1);
            nb_x_ok = (({1'b0, cur_x_ff} + DIM_W'(1)) < w_ff);
         end
         default: begin
            nb_x_ok = 1'b1;
         end
      endcase
      case (step.dy)
         STEP_DEC: begin
            nb_y    = cur_y_ff - COORD_W'(1);
            nb_y_ok = (cur_y_ff != '0);
         end
         STEP_INC: begin
            nb_y    = cur_y_ff + COORD_W'(1);
            nb_y_ok = (({1'b0, cur_y_ff} + DIM_W'(1)) < h_ff);
         end
         default: begin
            nb_y_ok = 1'b1;
         end
      endcase
      nb_ok = nb_x_ok && nb_y_ok;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (init_ptr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept && req_tuser == REQ_QUERY) begin
               state_in = start_out ? S_DONE : S_POP;
            end
         end
         S_POP: begin
            state_in = q_stat.empty ? S_DONE : S_FETCH;
         end
         S_FETCH: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            state_in = pix_rd_ff[0] ? S_DONE : S_NREAD;
         end
         S_NREAD: begin
            if (nb_ok) begin
               state_in = S_NCHK;
            end else if (nb_k_ff == NB_LAST) begin
               state_in = S_POP;
            end
         end
         S_NCHK: begin
            state_in = (nb_k_ff == NB_LAST) ? S_POP : S_NREAD;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff) state_in = S_CLEAN;
         end
         S_CLEAN: begin
            if (q_stat.empty && !clean_pend_ff) state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_tready  = 1'b0;
      img_we      = 1'b0;
      vis_we      = 1'b0;
      vis_wdata   = 1'b0;
      pix_wa      = nb_addr_ff;
      pix_rd_en   = 1'b0;
      pix_ra      = {nb_y, nb_x};
      q_ctl       = '0;
      q_push_data = nb_addr_ff;
      case (state_ff)
         S_INIT: begin
            vis_we = 1'b1;
            pix_wa = init_ptr_ff;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            pix_wa     = {pos_y, pos_x};
            if (req_accept) begin
               if (req_tuser == REQ_PIXEL) begin
                  img_we = 1'b1;
               end else if (!start_out) begin
                  vis_we      = 1'b1;
                  vis_wdata   = 1'b1;
                  q_ctl.push  = 1'b1;
                  q_push_data = {pos_y, pos_x};
               end
            end
         end
         S_POP: begin
            q_ctl.pop = !q_stat.empty;
         end
         S_FETCH: begin
            pix_rd_en = 1'b1;
            pix_ra    = q_rd_data;
         end
         S_NREAD: begin
            pix_rd_en = nb_ok;
         end
         S_NCHK: begin
            if (!pix_rd_ff[1]) begin
               vis_we     = 1'b1;
               vis_wdata  = 1'b1;
               q_ctl.push = 1'b1;
            end
         end
         S_DONE: begin
            q_ctl.rewind = !rsp_tvalid_ff;
         end
         S_CLEAN: begin
            q_ctl.pop = !q_stat.empty;
            vis_we    = clean_pend_ff;
            pix_wa    = q_rd_data;
            q_ctl.clear = q_stat.empty && !clean_pend_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ptr_ff   <= '0;
         clean_pend_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         width_ff      <= DIM_MAX;
         height_ff     <= DIM_MAX;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_INIT) init_ptr_ff <= init_ptr_ff + PIX_ADDR_W'(1);
         clean_pend_ff <= (state_ff == S_CLEAN) && !q_stat.empty;
         if (state_ff == S_DONE && !rsp_tvalid_ff) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
         end
      end
   end

   // search datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            w_ff     <= w_eff;
            h_ff     <= h_eff;
            found_ff <= 1'b0;
            res_x_ff <= '0;
            res_y_ff <= '0;
         end
         S_FETCH: begin
            cur_x_ff <= q_rd_data[COORD_W-1:0];
            cur_y_ff <= q_rd_data[PIX_ADDR_W-1:COORD_W];
         end
         S_TEST: begin
            nb_k_ff <= '0;
            if (pix_rd_ff[0]) begin
               found_ff <= 1'b1;
               res_x_ff <= cur_x_ff;
               res_y_ff <= cur_y_ff;
            end
         end
         S_NREAD: begin
            nb_addr_ff <= {nb_y, nb_x};
            if (!nb_ok) nb_k_ff <= nb_k_ff + NB_W'(1);
         end
         S_NCHK: begin
            nb_k_ff <= nb_k_ff + NB_W'(1);
         end
         S_DONE: begin
            if (!rsp_tvalid_ff) begin
               rsp_found_ff <= found_ff;
               rsp_x_ff     <= res_x_ff;
               rsp_y_ff     <= res_y_ff;
            end
         end
         default: begin
            nb_k_ff <= nb_k_ff;
         end
      endcase
   end

   // bit 0 image, bit 1 visited
   always_ff @(posedge clock) begin
      if (img_we) pix_mem[pix_wa][0] <= pixel_on;
      if (vis_we) pix_mem[pix_wa][1] <= vis_wdata;
      if (pix_rd_en) pix_rd_ff <= pix_mem[pix_ra];
   end

   nfps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_data (q_push_data),
      .rd_data   (q_rd_data),
      .stat      (q_stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};

   a_idle_queue_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> q_stat.empty)
      else $error("queue not drained when idle");

   a_miss_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_found_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("not-found result carries coordinates");

   a_hit_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_found_ff) |-> ({1'b0, rsp_x_ff} < w_ff && {1'b0, rsp_y_ff} < h_ff))
      else $error("result outside configured size");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(img_we && vis_we))
      else $error("image and visited written together");

endmodule

// ===== dv/tb_nearest_foreground_pixel_search.sv =====
module tb_nearest_foreground_pixel_search;
   import nfps_pkg::*;

   localparam int unsigned SIDE          = 256;
   localparam int unsigned SETTLE_CYCLES = 700;
   localparam int unsigned N_PHASES      = 11;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [23:0]      req_tdata   = '0;
   logic             req_tuser   = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [15:0]      rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we      = 1'b0;
   logic             csr_index   = 1'b0;
   logic [DIM_W-1:0] csr_wdata   = '0;

   int unsigned tx_idle_pct = 16;
   int unsigned rx_idle_pct = 69;

   // width value, height value, fill density in percent, random transactions
   int unsigned phase_w       [N_PHASES] = '{4, 1, 8, 256, 1, 0, 3, 6, 2, 7, 5};
   int unsigned phase_h       [N_PHASES] = '{4, 1, 4, 1, 511, 5, 5, 6, 2, 0, 6};
   int unsigned phase_density [N_PHASES] = '{30, 50, 10, 5, 5, 50, 0, 20, 60, 40, 25};
   int unsigned phase_count   [N_PHASES] = '{20, 10, 20, 20, 20, 10, 15, 20, 12, 10, 20};

   typedef struct packed {
      logic                found;
      logic [COORD_W-1:0]  near_x;
      logic [COORD_W-1:0]  near_y;
   } search_answer_type;

   class nearest_pixel_board;
      bit                image_bits [PIX_COUNT];
      int unsigned       visit_mark [PIX_COUNT];
      int unsigned       query_count;
      int unsigned       frontier [PIX_COUNT];
      int unsigned       front_head;
      int unsigned       front_tail;
      logic [DIM_W-1:0]  width_reg;
      logic [DIM_W-1:0]  height_reg;
      search_answer_type expected_answers [$];
      int                errors;

      function new();
         width_reg   = DIM_W'(SIDE);
         height_reg  = DIM_W'(SIDE);
         query_count = 0;
         front_head  = 0;
         front_tail  = 0;
         errors      = 0;
      endfunction

      function int unsigned used_dim(logic [DIM_W-1:0] value);
         return (value > SIDE) ? SIDE : int'(value);
      endfunction

      function void set_register(logic index, logic [DIM_W-1:0] value);
         if (index == CSR_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      function void queue_if_new(int unsigned x, int unsigned y);
         int unsigned idx;
         idx = y * SIDE + x;
         if (visit_mark[idx] != query_count) begin
            visit_mark[idx] = query_count;
            frontier[front_tail] = idx;
            front_tail++;
         end
      endfunction

      // breadth-first walk, 8-connected, neighbor order fixed
      function search_answer_type nearest_pixel(int unsigned sx, int unsigned sy);
         int unsigned       w, h, idx, cx, cy;
         bit                up_ok, dn_ok, lf_ok, rt_ok;
         search_answer_type ans;
         ans = '0;
         w = used_dim(width_reg);
         h = used_dim(height_reg);
         query_count++;
         front_head = 0;
         front_tail = 0;
         if (sx >= w || sy >= h) return ans;
         queue_if_new(sx, sy);
         while (front_head != front_tail) begin
            idx = frontier[front_head];
            front_head++;
            cx  = idx % SIDE;
            cy  = idx / SIDE;
            if (image_bits[idx]) begin
               ans.found  = 1'b1;
               ans.near_x = COORD_W'(cx);
               ans.near_y = COORD_W'(cy);
               return ans;
            end
            up_ok = cy > 0;
            dn_ok = cy + 1 < h;
            lf_ok = cx > 0;
            rt_ok = cx + 1 < w;
            if (up_ok) queue_if_new(cx, cy - 1);
            if (dn_ok) queue_if_new(cx, cy + 1);
            if (lf_ok) queue_if_new(cx - 1, cy);
            if (rt_ok) queue_if_new(cx + 1, cy);
            if (lf_ok && up_ok) queue_if_new(cx - 1, cy - 1);
            if (lf_ok && dn_ok) queue_if_new(cx - 1, cy + 1);
            if (rt_ok && up_ok) queue_if_new(cx + 1, cy - 1);
            if (rt_ok && dn_ok) queue_if_new(cx + 1, cy + 1);
         end
         return ans;
      endfunction

      function void note_request(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic lit);
         if (kind == REQ_PIXEL) begin
            image_bits[{y, x}] = lit;
         end else begin
            expected_answers.insert(expected_answers.size(), nearest_pixel(32'(x), 32'(y)));
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_answer(search_answer_type got);
         search_answer_type want;
         if (expected_answers.size() == 0) begin
            report($sformatf("result with none pending: found=%0d x=%0d y=%0d",
                             got.found, got.near_x, got.near_y));
            return;
         end
         want = expected_answers[0];
         expected_answers.delete(0);
         if (got.found !== want.found)
            report($sformatf("found %0d, want %0d", got.found, want.found));
         if (got.near_x !== want.near_x)
            report($sformatf("near_x %0d, want %0d", got.near_x, want.near_x));
         if (got.near_y !== want.near_y)
            report($sformatf("near_y %0d, want %0d", got.near_y, want.near_y));
      endtask
   endclass

   nearest_pixel_board board;

   nearest_foreground_pixel_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_answer({rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8]});
   end

   task automatic send_request(logic kind, int unsigned x, int unsigned y, logic lit);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, lit, COORD_W'(y), COORD_W'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, COORD_W'(x), COORD_W'(y), lit);
   endtask

   // drain pending answers, then let the visited-flag clean pass finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_dims(int unsigned w, int unsigned h);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= DIM_W'(w);
      @(posedge clock);
      board.set_register(CSR_WIDTH, DIM_W'(w));
      csr_index <= CSR_HEIGHT;
      csr_wdata <= DIM_W'(h);
      @(posedge clock);
      board.set_register(CSR_HEIGHT, DIM_W'(h));
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned w, h, x, y;
      logic        kind;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // full-size image, only the pixels a search will touch are written
      send_request(REQ_PIXEL, 0, 0, 1'b1);
      send_request(REQ_PIXEL, 255, 255, 1'b1);
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            send_request(REQ_PIXEL, 128 + dx, 128 + dy, dx == 1 && dy >= 0);
         end
      end
      send_request(REQ_PIXEL, 255, 0, 1'b0);
      send_request(REQ_PIXEL, 255, 1, 1'b0);
      send_request(REQ_PIXEL, 254, 0, 1'b0);
      send_request(REQ_PIXEL, 254, 1, 1'b1);
      send_request(REQ_PIXEL, 0, 255, 1'b0);
      send_request(REQ_PIXEL, 0, 254, 1'b0);
      send_request(REQ_PIXEL, 1, 255, 1'b0);
      send_request(REQ_PIXEL, 1, 254, 1'b1);
      send_request(REQ_QUERY, 0, 0, 1'b1);
      send_request(REQ_QUERY, 255, 255, 1'b0);
      send_request(REQ_QUERY, 128, 128, 1'b0);
      send_request(REQ_QUERY, 255, 0, 1'b1);
      send_request(REQ_QUERY, 0, 255, 1'b0);
      settle();
      set_dims(0, 256);
      send_request(REQ_QUERY, 0, 0, 1'b0);
      settle();
      set_dims(511, 1);
      send_request(REQ_QUERY, 0, 0, 1'b0);
      send_request(REQ_QUERY, 10, 5, 1'b1);

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         if (p == 4) begin
            tx_idle_pct = 69;
            rx_idle_pct = 16;
         end else if (p == 8) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         set_dims(phase_w[p], phase_h[p]);
         w = board.used_dim(board.width_reg);
         h = board.used_dim(board.height_reg);
         for (int fy = 0; fy < h; fy++) begin
            for (int fx = 0; fx < w; fx++) begin
               send_request(REQ_PIXEL, fx, fy, $urandom_range(99) < phase_density[p]);
            end
         end
         repeat (phase_count[p]) begin
            kind = ($urandom_range(99) < 55) ? REQ_QUERY : REQ_PIXEL;
            if (w != 0 && h != 0 && $urandom_range(99) < 82) begin
               x = $urandom_range(w - 1);
               y = $urandom_range(h - 1);
            end else begin
               x = $urandom_range(255);
               y = $urandom_range(255);
            end
            send_request(kind, x, y, $urandom_range(1));
         end
      end

      settle();
      if (board.errors == 0) begin
         $display("[nearest_foreground_pixel_search] OK");
      end else begin
         $display("[nearest_foreground_pixel_search] ERROR");
      end
      $finish;
   end

   initial begin
      #80000000;
      $display("[nearest_foreground_pixel_search] ERROR");
      $finish;
   end

endmodule
